>>> rtl/shelf_rect_allocator_unit_macros.svh
// assertion macros for the shelf allocator checker
`ifndef SHELF_RECT_ALLOCATOR_UNIT_MACROS_SVH
`define SHELF_RECT_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define SRA_ASSERT_NOW(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SRA_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> rtl/sra_pkg.sv
// shared types and constants of the shelf rectangle allocator
package sra_pkg;

   localparam int RECT_W     = 12;
   localparam int PAGE_IDX_W = 4;
   localparam int COORD_W    = 11;
   localparam int GUTTER     = 2;

   localparam int PAGE_SIDE_DEF        = 2048;
   localparam int MAX_PAGES_DEF        = 16;
   localparam int SHELVES_PER_PAGE_DEF = 256;

   typedef struct packed {
      logic [RECT_W-1:0] rect_width;
      logic [RECT_W-1:0] rect_height;
   } req_type;

   typedef struct packed {
      logic                  granted;
      logic [PAGE_IDX_W-1:0] page_index;
      logic [COORD_W-1:0]    inner_x;
      logic [COORD_W-1:0]    inner_y;
   } rsp_type;

endpackage

>>> rtl/shelf_rect_allocator_unit.sv
// top level of the first-fit shelf rectangle allocator
//
//  channel   ports                     direction  beat taken when
//  request   start, busy, req_data     in         start high and busy low
//  response  rsp_valid, rsp_data       out        every cycle rsp_valid is high
//
// one request at a time; after the accepted beat the sequencer runs a size check,
// then for each page visited a load and a closing scan, and for each shelf tried a
// registered read and a compare, skipping the closing scan when an existing shelf
// takes it; busy drops with the response strobe
// reset clears the sequencer and page count; stores are written before read
// the response cannot be stalled: rsp_valid is a one-cycle strobe
module shelf_rect_allocator_unit #(
   parameter int PAGE_SIDE        = sra_pkg::PAGE_SIDE_DEF,
   parameter int MAX_PAGES        = sra_pkg::MAX_PAGES_DEF,
   parameter int SHELVES_PER_PAGE = sra_pkg::SHELVES_PER_PAGE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sra_pkg::req_type req_data,
   output logic             rsp_valid,
   output sra_pkg::rsp_type rsp_data
);

   // widths following from the page geometry
   localparam int DIM_W       = $clog2(PAGE_SIDE + 1);
   localparam int SUM_W       = DIM_W + 1;
   localparam int PAD_W       = sra_pkg::RECT_W + 1;
   localparam int CMP_W       = (DIM_W > PAD_W) ? DIM_W : PAD_W;
   localparam int PO_W        = $clog2(MAX_PAGES + 1);
   localparam int PG_W        = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int CNT_W       = $clog2(SHELVES_PER_PAGE + 1);
   localparam int SHELF_DEPTH = MAX_PAGES * SHELVES_PER_PAGE;
   localparam int AW          = (SHELF_DEPTH > 1) ? $clog2(SHELF_DEPTH) : 1;
   localparam int ENTRY_W     = 3 * DIM_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PAGE,
      ST_SCAN,
      ST_CMP
   } state_type;

   state_type             state_ff, state_in;
   logic [CMP_W-1:0]      pw_ff, pw_in;
   logic [CMP_W-1:0]      ph_ff, ph_in;
   logic [PO_W-1:0]       pages_open_ff, pages_open_in;
   logic [PG_W-1:0]       page_ff, page_in;
   logic [AW-1:0]         base_ff, base_in;
   logic [AW-1:0]         addr_ff, addr_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CNT_W-1:0]      shelf_ff, shelf_in;
   logic [DIM_W-1:0]      fill_ff, fill_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sra_pkg::rsp_type      rsp_ff, rsp_in;

   // page stores, written only when a page opens or gains a shelf
   logic [DIM_W-1:0]      page_fill_ff  [MAX_PAGES];
   logic [CNT_W-1:0]      page_count_ff [MAX_PAGES];
   logic                  page_wr;
   logic [DIM_W-1:0]      page_wr_fill;
   logic [CNT_W-1:0]      page_wr_count;

   // shelf memory: {top, height, fill_x}
   logic [ENTRY_W-1:0]    shelf_mem [SHELF_DEPTH];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [AW-1:0]         rd_addr;
   logic                  mem_wr;
   logic [AW-1:0]         mem_wr_addr;
   logic [ENTRY_W-1:0]    mem_wr_data;

   // padded size and shared add/compare unit
   logic [DIM_W-1:0]      pw_d, ph_d;
   logic [DIM_W-1:0]      ent_top, ent_height, ent_fill;
   logic [SUM_W-1:0]      add_a, add_b, add_sum;
   logic                  add_fits;
   logic [CMP_W-1:0]      pad_w, pad_h;
   logic                  new_page;

   assign pw_d       = pw_ff[DIM_W-1:0];
   assign ph_d       = ph_ff[DIM_W-1:0];
   assign ent_top    = rd_data_ff[ENTRY_W-1 -: DIM_W];
   assign ent_height = rd_data_ff[2*DIM_W-1 -: DIM_W];
   assign ent_fill   = rd_data_ff[DIM_W-1:0];
   assign pad_w      = CMP_W'(req_data.rect_width) + CMP_W'(sra_pkg::GUTTER);
   assign pad_h      = CMP_W'(req_data.rect_height) + CMP_W'(sra_pkg::GUTTER);
   assign new_page   = (PO_W'(page_ff) >= pages_open_ff);

   // one adder and one limit compare, shared by shelf fit and new shelf
   always_comb begin
      if (state_ff == ST_CMP) begin
         add_a = SUM_W'(ent_fill);
         add_b = SUM_W'(pw_d);
      end else begin
         add_a = SUM_W'(fill_ff);
         add_b = SUM_W'(ph_d);
      end
   end
   assign add_sum  = add_a + add_b;
   assign add_fits = (add_sum <= SUM_W'(PAGE_SIDE));

   assign rd_addr = base_ff + AW'(shelf_ff);

   always_comb begin
      state_in      = state_ff;
      pw_in         = pw_ff;
      ph_in         = ph_ff;
      pages_open_in = pages_open_ff;
      page_in       = page_ff;
      base_in       = base_ff;
      addr_in       = addr_ff;
      cnt_in        = cnt_ff;
      shelf_in      = shelf_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = '0;
      page_wr       = 1'b0;
      page_wr_fill  = '0;
      page_wr_count = '0;
      mem_wr        = 1'b0;
      mem_wr_addr   = rd_addr;
      mem_wr_data   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               pw_in    = pad_w;
               ph_in    = pad_h;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // too large for any page: refuse without touching state
            if (pw_ff > CMP_W'(PAGE_SIDE) || ph_ff > CMP_W'(PAGE_SIDE)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               page_in  = '0;
               base_in  = '0;
               state_in = ST_PAGE;
            end
         end
         ST_PAGE: begin
            shelf_in = '0;
            if (new_page) begin
               page_wr       = 1'b1;
               pages_open_in = PO_W'(page_ff) + PO_W'(1);
               cnt_in        = '0;
               fill_in       = '0;
            end else begin
               cnt_in  = page_count_ff[page_ff];
               fill_in = page_fill_ff[page_ff];
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (shelf_ff < cnt_ff) begin
               addr_in  = rd_addr;
               state_in = ST_CMP;
            end else if (cnt_ff < CNT_W'(SHELVES_PER_PAGE) && add_fits) begin
               // open a new shelf at the page fill height
               mem_wr             = 1'b1;
               mem_wr_addr        = rd_addr;
               mem_wr_data        = {fill_ff, ph_d, pw_d};
               page_wr            = 1'b1;
               page_wr_fill       = add_sum[DIM_W-1:0];
               page_wr_count      = cnt_ff + CNT_W'(1);
               rsp_valid_in       = 1'b1;
               rsp_in.granted     = 1'b1;
               rsp_in.page_index  = sra_pkg::PAGE_IDX_W'(page_ff);
               rsp_in.inner_x     = sra_pkg::COORD_W'(1);
               rsp_in.inner_y     = sra_pkg::COORD_W'(SUM_W'(fill_ff) + SUM_W'(1));
               state_in           = ST_IDLE;
            end else if (page_ff == PG_W'(MAX_PAGES - 1)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               page_in  = page_ff + PG_W'(1);
               base_in  = base_ff + AW'(SHELVES_PER_PAGE);
               state_in = ST_PAGE;
            end
         end
         ST_CMP: begin
            if (ph_d <= ent_height && add_fits) begin
               mem_wr            = 1'b1;
               mem_wr_addr       = addr_ff;
               mem_wr_data       = {ent_top, ent_height, add_sum[DIM_W-1:0]};
               rsp_valid_in      = 1'b1;
               rsp_in.granted    = 1'b1;
               rsp_in.page_index = sra_pkg::PAGE_IDX_W'(page_ff);
               rsp_in.inner_x    = sra_pkg::COORD_W'(SUM_W'(ent_fill) + SUM_W'(1));
               rsp_in.inner_y    = sra_pkg::COORD_W'(SUM_W'(ent_top) + SUM_W'(1));
               state_in          = ST_IDLE;
            end else begin
               shelf_in = shelf_ff + CNT_W'(1);
               state_in = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pages_open_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pages_open_ff <= pages_open_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pw_ff    <= pw_in;
      ph_ff    <= ph_in;
      page_ff  <= page_in;
      base_ff  <= base_in;
      addr_ff  <= addr_in;
      cnt_ff   <= cnt_in;
      shelf_ff <= shelf_in;
      fill_ff  <= fill_in;
      rsp_ff   <= rsp_in;
   end

   // page stores
   always_ff @(posedge clock) begin
      if (page_wr) begin
         page_fill_ff[page_ff]  <= page_wr_fill;
         page_count_ff[page_ff] <= page_wr_count;
      end
   end

   // shelf memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         shelf_mem[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= shelf_mem[rd_addr];
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/sra_checker.sv
// port checker for the shelf rectangle allocator, bound to the top level
`include "shelf_rect_allocator_unit_macros.svh"

module sra_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input sra_pkg::rsp_type rsp_data
);

   logic req_beat;

   assign req_beat = start && !busy;

   // an accepted beat must raise busy
   `SRA_ASSERT_NEXT(a_accept_busy, req_beat, busy, "accepted request did not raise busy")

   // the response strobe closes the busy period
   `SRA_ASSERT_NOW(a_rsp_ends_busy, rsp_valid, !busy && $past(busy), "response outside busy period")

   // a strobe lasts one cycle only
   `SRA_ASSERT_NEXT(a_rsp_strobe, rsp_valid, !rsp_valid, "response strobe longer than one cycle")

   // a refusal carries zero placement
   `SRA_ASSERT_NOW(a_refuse_zero, rsp_valid && !rsp_data.granted,
      rsp_data.page_index == '0 && rsp_data.inner_x == '0 && rsp_data.inner_y == '0,
      "refused response with non-zero placement")

endmodule

bind shelf_rect_allocator_unit sra_checker u_sra_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
